// ===== src/spl_pkg.sv =====
`timescale 1ns / 1ps

package spl_pkg;

  // Item kinds
  localparam logic FuncEdge = 1'b0;
  localparam logic FuncTick = 1'b1;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegCoarseWindow = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFineWindow   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegLockWindow   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegUnlockWindow = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCoarseStep   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFineStep     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOutHighLimit = 3'd6;
  localparam logic [CfgIdxW-1:0] RegOutLowLimit  = 3'd7;

  localparam int CfgDataW = 32;

  // Register reset values
  localparam logic [31:0] CoarseWindowRst = 32'h9000_7000;
  localparam logic [31:0] FineWindowRst   = 32'h8400_7C00;
  localparam logic [31:0] LockWindowRst   = 32'h8200_7E00;
  localparam logic [31:0] UnlockWindowRst = 32'h8800_7800;
  localparam logic [11:0] CoarseStepRst   = 12'd256;
  localparam logic [11:0] FineStepRst     = 12'd32;
  localparam logic [12:0] OutHighLimitRst = 13'd2000;
  localparam logic [12:0] OutLowLimitRst  = 13'd1000;

  // Lock and idle thresholds
  localparam logic [2:0] LockEdges   = 3'd4;
  localparam logic [4:0] UnlockEdges = 5'd20;
  localparam logic [2:0] IdleTicks   = 3'd5;
  localparam logic [2:0] IdleSat     = 3'd7;

  typedef struct packed {
    logic [15:0] hi;
    logic [15:0] lo;
  } window_t;

  typedef struct packed {
    window_t     coarse_window;
    window_t     fine_window;
    window_t     lock_window;
    window_t     unlock_window;
    logic [11:0] coarse_step;
    logic [11:0] fine_step;
    logic [12:0] out_high_limit;
    logic [12:0] out_low_limit;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [15:0] phase;
    logic [12:0] out_high_rms;
    logic [12:0] out_low_rms;
    logic        in_fault;
    logic        bus_low;
  } item_t;

  typedef struct packed {
    logic [15:0] phase_out;
    logic        phase_write;
    logic        self_out_en;
    logic        sync_locked;
    logic        async_warning;
    logic        sync_line_fault;
    logic        sync_problem;
    logic        soft_start_en;
    logic        release_bus;
    logic        assert_primary;
  } result_t;

endpackage

// ===== src/spl_if.sv =====
`timescale 1ns / 1ps

interface spl_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] phase;
  logic [12:0] out_high_rms;
  logic [12:0] out_low_rms;
  logic        in_fault;
  logic        bus_low;

  modport source (
    output valid, func, phase, out_high_rms, out_low_rms, in_fault, bus_low,
    input  ready
  );
  modport sink (
    input  valid, func, phase, out_high_rms, out_low_rms, in_fault, bus_low,
    output ready
  );
endinterface

interface spl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] phase_out;
  logic        phase_write;
  logic        self_out_en;
  logic        sync_locked;
  logic        async_warning;
  logic        sync_line_fault;
  logic        sync_problem;
  logic        soft_start_en;
  logic        release_bus;
  logic        assert_primary;

  modport source (
    output valid, phase_out, phase_write, self_out_en, sync_locked, async_warning,
           sync_line_fault, sync_problem, soft_start_en, release_bus, assert_primary,
    input  ready
  );
  modport sink (
    input  valid, phase_out, phase_write, self_out_en, sync_locked, async_warning,
           sync_line_fault, sync_problem, soft_start_en, release_bus, assert_primary,
    output ready
  );
endinterface

// ===== src/spl_cfg_regs.sv =====
`timescale 1ns / 1ps

module spl_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [spl_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output spl_pkg::cfg_t                 cfg_o
);
  import spl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoarseWindow: cfg_d.coarse_window  = cfg_wdata_i;
        RegFineWindow:   cfg_d.fine_window    = cfg_wdata_i;
        RegLockWindow:   cfg_d.lock_window    = cfg_wdata_i;
        RegUnlockWindow: cfg_d.unlock_window  = cfg_wdata_i;
        RegCoarseStep:   cfg_d.coarse_step    = cfg_wdata_i[11:0];
        RegFineStep:     cfg_d.fine_step      = cfg_wdata_i[11:0];
        RegOutHighLimit: cfg_d.out_high_limit = cfg_wdata_i[12:0];
        RegOutLowLimit:  cfg_d.out_low_limit  = cfg_wdata_i[12:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coarse_window  <= CoarseWindowRst;
      cfg_q.fine_window    <= FineWindowRst;
      cfg_q.lock_window    <= LockWindowRst;
      cfg_q.unlock_window  <= UnlockWindowRst;
      cfg_q.coarse_step    <= CoarseStepRst;
      cfg_q.fine_step      <= FineStepRst;
      cfg_q.out_high_limit <= OutHighLimitRst;
      cfg_q.out_low_limit  <= OutLowLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/spl_step.sv =====
`timescale 1ns / 1ps

// Lock/master state and the per-item update. State advances on step_en_i;
// res_o shows the result of the item on item_i against the current state.
module spl_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  spl_pkg::item_t    item_i,
  input  spl_pkg::cfg_t     cfg_i,
  output spl_pkg::result_t  res_o
);
  import spl_pkg::*;

  logic [2:0] idle_q, idle_d;
  logic [2:0] lock_cnt_q, lock_cnt_d;
  logic [4:0] unlock_cnt_q, unlock_cnt_d;
  logic       self_out_q, self_out_d;
  logic       locked_q, locked_d;
  logic       warn_q, warn_d;
  logic       line_fault_q, line_fault_d;
  logic       problem_q, problem_d;
  logic       soft_start_q, soft_start_d;

  logic [15:0] ph;
  logic [15:0] ph_corr;
  logic        corr_wr;
  logic [2:0]  lock_inc;
  logic [4:0]  unlock_inc;
  logic [2:0]  idle_inc;
  logic        out_present;

  assign ph          = item_i.phase;
  assign lock_inc    = lock_cnt_q + 3'd1;
  assign unlock_inc  = unlock_cnt_q + 5'd1;
  assign idle_inc    = (idle_q < IdleSat) ? idle_q + 3'd1 : idle_q;
  assign out_present = (item_i.out_high_rms >= cfg_i.out_high_limit) ||
                       (item_i.out_low_rms >= cfg_i.out_low_limit);

  // Phase correction, first matching window wins
  always_comb begin
    ph_corr = ph;
    corr_wr = 1'b1;
    if (ph <= cfg_i.coarse_window.lo) begin
      ph_corr = ph + {4'b0, cfg_i.coarse_step};
    end else if (ph >= cfg_i.coarse_window.hi) begin
      ph_corr = ph - {4'b0, cfg_i.coarse_step};
    end else if (ph <= cfg_i.fine_window.lo) begin
      ph_corr = ph + {4'b0, cfg_i.fine_step};
    end else if (ph >= cfg_i.fine_window.hi) begin
      ph_corr = ph - {4'b0, cfg_i.fine_step};
    end else begin
      corr_wr = 1'b0;
    end
  end

  always_comb begin
    idle_d       = idle_q;
    lock_cnt_d   = lock_cnt_q;
    unlock_cnt_d = unlock_cnt_q;
    self_out_d   = self_out_q;
    locked_d     = locked_q;
    warn_d       = warn_q;
    line_fault_d = line_fault_q;
    problem_d    = problem_q;
    soft_start_d = soft_start_q;

    res_o                = '0;
    res_o.phase_out      = ph;

    if (item_i.func == FuncEdge) begin
      idle_d               = '0;
      soft_start_d         = 1'b1;
      res_o.release_bus    = !item_i.in_fault && item_i.bus_low;
      res_o.phase_out      = ph_corr;
      res_o.phase_write    = corr_wr;
      if (!locked_q) begin
        if (ph_corr >= cfg_i.lock_window.lo && ph_corr <= cfg_i.lock_window.hi) begin
          lock_cnt_d = lock_inc;
          if (lock_inc > LockEdges) begin
            self_out_d   = 1'b1;
            locked_d     = 1'b1;
            warn_d       = 1'b0;
            lock_cnt_d   = '0;
            unlock_cnt_d = '0;
          end
        end else begin
          lock_cnt_d = '0;
        end
      end else begin
        if (ph_corr <= cfg_i.unlock_window.lo || ph_corr >= cfg_i.unlock_window.hi) begin
          unlock_cnt_d = unlock_inc;
          if (unlock_inc > UnlockEdges) begin
            self_out_d   = 1'b0;
            locked_d     = 1'b0;
            warn_d       = 1'b1;
            unlock_cnt_d = '0;
            lock_cnt_d   = '0;
          end
        end else begin
          unlock_cnt_d = '0;
        end
      end
    end else begin
      idle_d = idle_inc;
      if (idle_inc >= IdleTicks) begin
        if (!self_out_q) begin
          // nobody drives the bus: take it over
          self_out_d        = 1'b1;
          res_o.release_bus = 1'b1;
          idle_d            = '0;
        end else if (out_present) begin
          if (!item_i.in_fault) begin
            line_fault_d = 1'b1;
            idle_d       = '0;
          end
        end else begin
          problem_d            = 1'b1;
          self_out_d           = 1'b0;
          idle_d               = '0;
          res_o.phase_out      = '0;
          res_o.phase_write    = 1'b1;
          res_o.assert_primary = 1'b1;
        end
      end
    end

    res_o.self_out_en     = self_out_d;
    res_o.sync_locked     = locked_d;
    res_o.async_warning   = warn_d;
    res_o.sync_line_fault = line_fault_d;
    res_o.sync_problem    = problem_d;
    res_o.soft_start_en   = soft_start_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q       <= '0;
      lock_cnt_q   <= '0;
      unlock_cnt_q <= '0;
      self_out_q   <= 1'b0;
      locked_q     <= 1'b0;
      warn_q       <= 1'b0;
      line_fault_q <= 1'b0;
      problem_q    <= 1'b0;
      soft_start_q <= 1'b0;
    end else if (step_en_i) begin
      idle_q       <= idle_d;
      lock_cnt_q   <= lock_cnt_d;
      unlock_cnt_q <= unlock_cnt_d;
      self_out_q   <= self_out_d;
      locked_q     <= locked_d;
      warn_q       <= warn_d;
      line_fault_q <= line_fault_d;
      problem_q    <= problem_d;
      soft_start_q <= soft_start_d;
    end
  end

endmodule

// ===== src/sync_phase_lock_and_master_select.sv =====
`timescale 1ns / 1ps

// A request is captured in the input register (item_q); when it moves on, its result
//   is written to the output register (res_q), from which it can be taken.
// Throughput: one request per cycle, set by the input and result registers, unless res_o.ready stalls.
// Reset (rst_ni low, asynchronous): counters and flags clear, configuration
//   registers return to their defaults, both stages go empty.
module sync_phase_lock_and_master_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  spl_in_if.sink                        req_i,
  spl_out_if.source                     res_o,
  input  logic                          cfg_we_i,
  input  logic [spl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [spl_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import spl_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q, in_valid_d;
  result_t res_next;
  result_t res_q;
  logic    out_valid_q, out_valid_d;
  logic    accept;
  logic    advance;

  // Configuration register file
  spl_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The registered request moves to the result register when that register is
  // empty or being drained this cycle. Lock/master state commits on the move.
  assign advance = in_valid_q && (!out_valid_q || res_o.ready);
  assign accept  = req_i.valid && req_i.ready;

  // Input stage can take a new request when it is empty or its content leaves this cycle.
  assign req_i.ready = !in_valid_q || advance;

  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.func         <= req_i.func;
      item_q.phase        <= req_i.phase;
      item_q.out_high_rms <= req_i.out_high_rms;
      item_q.out_low_rms  <= req_i.out_low_rms;
      item_q.in_fault     <= req_i.in_fault;
      item_q.bus_low      <= req_i.bus_low;
    end
    if (advance) begin
      res_q <= res_next;
    end
  end

  // Phase correction, lock tracking and idle-tick master selection
  spl_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .item_i    (item_q),
    .cfg_i     (cfg),
    .res_o     (res_next)
  );

  assign res_o.valid           = out_valid_q;
  assign res_o.phase_out       = res_q.phase_out;
  assign res_o.phase_write     = res_q.phase_write;
  assign res_o.self_out_en     = res_q.self_out_en;
  assign res_o.sync_locked     = res_q.sync_locked;
  assign res_o.async_warning   = res_q.async_warning;
  assign res_o.sync_line_fault = res_q.sync_line_fault;
  assign res_o.sync_problem    = res_q.sync_problem;
  assign res_o.soft_start_en   = res_q.soft_start_en;
  assign res_o.release_bus     = res_q.release_bus;
  assign res_o.assert_primary  = res_q.assert_primary;

  // Lock and loss-of-lock warning are exclusive: gaining lock clears the
  // warning, losing lock sets it.
  a_lock_warn_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.sync_locked && res_q.async_warning))
    else $error("sync_locked and async_warning both set");

  // Driving the primary line always comes with a phase reset to zero.
  a_primary_phase_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.assert_primary) |->
      (res_q.phase_write && res_q.phase_out == 16'd0 && !res_q.self_out_en))
    else $error("assert_primary without phase reset");

  // Taking over the bus and driving the primary line are separate outcomes.
  a_release_primary_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.release_bus && res_q.assert_primary))
    else $error("release_bus and assert_primary in one result");

  // A request that moves on always lands in the result register next cycle.
  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result lost after stage advance");

endmodule
